### rtl/pfc_pkg.sv
// pfc_pkg: shared types, letter codes and register indexes for the Playfair digram unit.
// No dependencies; imported by every module of the block except pfc_fifo.
package pfc_pkg;

	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_X = 5'd23;
	localparam logic [4:0] LETTER_Z = 5'd25;

	localparam int SQ = 5;

	// configuration register indexes
	localparam logic [2:0] CFG_KEY_ROW_0 = 3'd0;
	localparam logic [2:0] CFG_KEY_ROW_1 = 3'd1;
	localparam logic [2:0] CFG_KEY_ROW_2 = 3'd2;
	localparam logic [2:0] CFG_KEY_ROW_3 = 3'd3;
	localparam logic [2:0] CFG_KEY_ROW_4 = 3'd4;
	localparam logic [2:0] CFG_MODE      = 3'd5;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// row r in [r], column c in bits [5c+4:5c]
	typedef logic [SQ-1:0][24:0] key_sq_t;

	typedef struct packed {
		logic [4:0] a;
		logic [4:0] b;
		logic       last;
	} digram_t;

	typedef struct packed {
		logic [4:0] letter;
		logic       last;
	} out_word_t;

	// dual write into a queue; en1 only ever with en0
	typedef struct packed {
		logic    en0;
		logic    en1;
		digram_t d0;
		digram_t d1;
	} dq_write_t;

	typedef struct packed {
		logic      en0;
		logic      en1;
		out_word_t w0;
		out_word_t w1;
	} oq_write_t;

	typedef struct packed {
		logic valid;
		logic fire;
	} back_stat_t;

	function automatic logic [4:0] fold(input logic [4:0] v);
		return (v == LETTER_J) ? LETTER_I : v;
	endfunction

endpackage

### rtl/pfc_fifo.sv
// pfc_fifo: small register queue, two write ports, one read port, level output.
// Standalone; used for both the digram queue and the result queue.
module pfc_fifo #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en0,
	input  logic [WIDTH-1:0]             wr_data0,
	input  logic                         wr_en1,
	input  logic [WIDTH-1:0]             wr_data1,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic [$clog2(DEPTH+1)-1:0]   level
);
	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PW-1:0] wptr_q, rptr_q, wptr1;
	logic [LW-1:0] level_q;
	logic          do_rd;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	assign wptr1   = nxt(wptr_q);
	assign do_rd   = rd_en && (level_q != '0);
	assign rd_data = mem_q[rptr_q];
	assign level   = level_q;

	always_ff @(posedge clk) begin
		if (wr_en0) begin
			mem_q[wptr_q] <= wr_data0;
		end
		if (wr_en0 && wr_en1) begin
			mem_q[wptr1] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (wr_en0 && wr_en1) begin
				wptr_q <= nxt(wptr1);
			end else if (wr_en0) begin
				wptr_q <= wptr1;
			end
			if (do_rd) begin
				rptr_q <= nxt(rptr_q);
			end
			level_q <= level_q + LW'(wr_en0) + LW'(wr_en0 && wr_en1) - LW'(do_rd);
		end
	end

endmodule

### rtl/pfc_front.sv
// pfc_front: folds letters, pairs them into digrams and inserts fillers.
// Depends on pfc_pkg; drives the digram queue write ports.
module pfc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [4:0]         letter,
	input  logic               message_end,
	output pfc_pkg::dq_write_t dq_wr
);
	import pfc_pkg::*;

	logic [4:0] held_letter_q;
	logic       held_valid_q;
	logic [4:0] l;

	function automatic logic [4:0] filler(input logic [4:0] v);
		return (v == LETTER_Z) ? LETTER_X : LETTER_Z;
	endfunction

	assign l = fold(letter);

	always_comb begin
		dq_wr = '0;
		dq_wr.d0 = '{a: l, b: filler(l), last: 1'b1};
		dq_wr.d1 = '{a: l, b: filler(l), last: 1'b1};
		if (take) begin
			if (held_valid_q) begin
				if (l != held_letter_q) begin
					dq_wr.en0 = 1'b1;
					dq_wr.d0  = '{a: held_letter_q, b: l, last: message_end};
				end else begin
					// doubled letter: close the held one with a filler
					dq_wr.en0 = 1'b1;
					dq_wr.d0  = '{a: held_letter_q, b: filler(held_letter_q), last: 1'b0};
					dq_wr.en1 = message_end;
				end
			end else begin
				dq_wr.en0 = message_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
		end else if (take) begin
			if (held_valid_q && (l != held_letter_q)) begin
				held_valid_q <= 1'b0;
			end else begin
				held_valid_q  <= !message_end;
				held_letter_q <= l;
			end
		end
	end

endmodule

### rtl/pfc_back.sv
// pfc_back: locates both digram letters in the key square, then substitutes them.
// Depends on pfc_pkg; reads the digram queue, writes two result words at a time.
module pfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pfc_pkg::key_sq_t    key,
	input  logic                mode,
	input  pfc_pkg::digram_t    dq_head,
	input  logic                dq_avail,
	input  logic                oq_room,
	output logic                dq_pop,
	output pfc_pkg::oq_write_t  oq_wr,
	output pfc_pkg::back_stat_t stat
);
	import pfc_pkg::*;

	logic [2:0] r1_s1, c1_s1, r2_s1, c2_s1;
	logic       last_s1;
	logic       valid_s1;
	logic       fire;
	logic [2:0] r1, c1, r2, c2;
	logic [2:0] ro1, co1, ro2, co2;

	function automatic logic [4:0] sq_cell(input key_sq_t k, input logic [2:0] r,
			input logic [2:0] c);
		return k[r][5*c +: 5];
	endfunction

	function automatic logic [2:0] inc5(input logic [2:0] v);
		return (v == 3'd4) ? 3'd0 : v + 3'd1;
	endfunction

	function automatic logic [2:0] dec5(input logic [2:0] v);
		return (v == 3'd0) ? 3'd4 : v - 3'd1;
	endfunction

	// first matching cell in row-major order, else cell 0,0
	function automatic logic [5:0] locate(input key_sq_t k, input logic [4:0] v);
		logic [SQ-1:0][SQ-1:0] hit;
		logic [SQ-1:0]         row_hit;
		logic [2:0]            r, c;
		for (int i = 0; i < SQ; i++) begin
			for (int j = 0; j < SQ; j++) begin
				hit[i][j] = (fold(k[i][5*j +: 5]) == v);
			end
			row_hit[i] = |hit[i];
		end
		r = 3'd0;
		for (int i = SQ-1; i >= 0; i--) begin
			if (row_hit[i]) r = 3'(i);
		end
		c = 3'd0;
		for (int j = SQ-1; j >= 0; j--) begin
			if (hit[r][j]) c = 3'(j);
		end
		return {r, c};
	endfunction

	assign fire   = valid_s1 && oq_room;
	assign dq_pop = dq_avail && (!valid_s1 || fire);
	assign stat   = '{valid: valid_s1, fire: fire};

	assign {r1, c1} = locate(key, dq_head.a);
	assign {r2, c2} = locate(key, dq_head.b);

	always_ff @(posedge clk) begin
		if (dq_pop) begin
			r1_s1   <= r1;
			c1_s1   <= c1;
			r2_s1   <= r2;
			c2_s1   <= c2;
			last_s1 <= dq_head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (dq_pop) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		ro1 = r1_s1;
		co1 = c2_s1;
		ro2 = r2_s1;
		co2 = c1_s1;
		if (r1_s1 == r2_s1) begin
			co1 = (mode == MODE_DECRYPT) ? dec5(c1_s1) : inc5(c1_s1);
			co2 = (mode == MODE_DECRYPT) ? dec5(c2_s1) : inc5(c2_s1);
		end else if (c1_s1 == c2_s1) begin
			ro1 = (mode == MODE_DECRYPT) ? dec5(r1_s1) : inc5(r1_s1);
			ro2 = (mode == MODE_DECRYPT) ? dec5(r2_s1) : inc5(r2_s1);
			co1 = c1_s1;
			co2 = c2_s1;
		end
	end

	always_comb begin
		oq_wr.en0 = fire;
		oq_wr.en1 = fire;
		oq_wr.w0  = '{letter: sq_cell(key, ro1, co1), last: 1'b0};
		oq_wr.w1  = '{letter: sq_cell(key, ro2, co2), last: last_s1};
	end

endmodule

### rtl/playfair_digram_cipher_unit.sv
// playfair_digram_cipher_unit: top level of the Playfair digram unit.
// Depends on pfc_pkg, pfc_fifo, pfc_front and pfc_back.
//
//  channel   handshake            words
//  --------  -------------------  ---------------------------------------
//  input     push / full          letter[4:0], message_end
//  result    pop / empty          out_letter[4:0], out_last
//  config    cfg_we               cfg_idx[2:0], cfg_data[24:0]
//
// One input word can be taken every cycle; the front stalls (full) only when the
// digram queue has fewer than two free slots. The back substitutes one digram per
// cycle while the result queue has two free slots and writes two result words at
// once, so the result side drains one word a cycle and sets the sustained rate.
// Reset clears queues, the held letter, the key square and the mode; no clearing
// pass. Either side may stall without loss.
module playfair_digram_cipher_unit #(
	parameter int DQ_DEPTH = 4,
	parameter int OQ_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  letter,
	input  logic        message_end,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  out_letter,
	output logic        out_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [24:0] cfg_data
);
	import pfc_pkg::*;

	localparam int DLW = $clog2(DQ_DEPTH+1);
	localparam int OLW = $clog2(OQ_DEPTH+1);
	localparam int DW  = $bits(digram_t);
	localparam int OW  = $bits(out_word_t);

	key_sq_t    key_q;
	logic       mode_q;

	dq_write_t  dq_wr;
	digram_t    dq_head;
	logic [DLW-1:0] dq_level;
	logic       dq_pop;

	oq_write_t  oq_wr;
	out_word_t  oq_head;
	logic [OLW-1:0] oq_level;
	logic       oq_room;
	back_stat_t back_stat;
	logic       take;

	// config: the user must write it only while idle (the block does not enforce this), so no shadowing needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= MODE_ENCRYPT;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_KEY_ROW_0: key_q[0] <= cfg_data;
				CFG_KEY_ROW_1: key_q[1] <= cfg_data;
				CFG_KEY_ROW_2: key_q[2] <= cfg_data;
				CFG_KEY_ROW_3: key_q[3] <= cfg_data;
				CFG_KEY_ROW_4: key_q[4] <= cfg_data;
				CFG_MODE:      mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a word may push two digrams, so keep two slots in hand
	assign full    = (dq_level > DLW'(DQ_DEPTH-2));
	assign take    = push && !full;
	assign oq_room = (oq_level <= OLW'(OQ_DEPTH-2));

	pfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.letter      (letter),
		.message_end (message_end),
		.dq_wr       (dq_wr)
	);

	pfc_fifo #(.WIDTH(DW), .DEPTH(DQ_DEPTH)) u_dq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en0   (dq_wr.en0),
		.wr_data0 (dq_wr.d0),
		.wr_en1   (dq_wr.en1),
		.wr_data1 (dq_wr.d1),
		.rd_en    (dq_pop),
		.rd_data  (dq_head),
		.level    (dq_level)
	);

	pfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.mode     (mode_q),
		.dq_head  (dq_head),
		.dq_avail (dq_level != '0),
		.oq_room  (oq_room),
		.dq_pop   (dq_pop),
		.oq_wr    (oq_wr),
		.stat     (back_stat)
	);

	pfc_fifo #(.WIDTH(OW), .DEPTH(OQ_DEPTH)) u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en0   (oq_wr.en0),
		.wr_data0 (oq_wr.w0),
		.wr_en1   (oq_wr.en1),
		.wr_data1 (oq_wr.w1),
		.rd_en    (pop),
		.rd_data  (oq_head),
		.level    (oq_level)
	);

	assign empty      = (oq_level == '0);
	assign out_letter = oq_head.letter;
	assign out_last   = oq_head.last;

	// queues never overrun
	a_dq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dq_level <= DLW'(DQ_DEPTH))
		else $error("digram queue overrun");

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_level <= OLW'(OQ_DEPTH))
		else $error("result queue overrun");

	// a substituted digram leaves at least one word to read next cycle
	a_fire_fill: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.fire |=> !empty)
		else $error("substituted digram lost");

	// a blocked back stage holds its digram
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.valid && !back_stat.fire |=> back_stat.valid)
		else $error("back stage dropped a digram");

endmodule
